[src/sbsm_pkg.sv]
package sbsm_pkg;

	localparam int PRG_SLOTS = 4;
	localparam int CHR_SLOTS = 8;

	typedef enum logic [1:0] {
		KIND_WRITE      = 2'd0,
		KIND_READ       = 2'd1,
		KIND_PRG_LOOKUP = 2'd2,
		KIND_CHR_LOOKUP = 2'd3
	} kind_t;

	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_CHR0    = 2'd1;
	localparam logic [1:0] REG_CHR1    = 2'd2;
	localparam logic [1:0] REG_PRG     = 2'd3;

	localparam logic CFG_PRG_PAGE_COUNT  = 1'b0;
	localparam logic CFG_CHR_ROM_PRESENT = 1'b1;

	localparam logic [5:0] PRG_PAGE_COUNT_RESET = 6'd32;
	localparam logic [4:0] CONTROL_RESET        = 5'h0C;
	localparam logic [4:0] CTL_RESET_BITS       = 5'h0C;
	localparam logic [2:0] SHIFT_BITS           = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] region;
		logic [7:0] data;
		logic [2:0] slot;
	} item_t;

	typedef struct packed {
		logic [4:0] read_value;
		logic [6:0] page;
		logic       committed;
		logic [1:0] written_register;
		logic [1:0] mirroring;
	} result_t;

endpackage

[src/sbsm_core.sv]
module sbsm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [5:0]       prg_page_count,
	input  logic             chr_rom_present,
	input  logic             step,
	input  sbsm_pkg::item_t  item,
	output sbsm_pkg::result_t result
);
	import sbsm_pkg::*;

	logic [4:0] shift_value_q, shift_value_d;
	logic [2:0] shift_count_q, shift_count_d;
	logic [1:0] last_region_q, last_region_d;
	logic [4:0] regs_q [4];
	logic [4:0] regs_d [4];
	logic [4:0] prg_q [PRG_SLOTS];
	logic [4:0] prg_d [PRG_SLOTS];
	logic [6:0] chr_q [CHR_SLOTS];
	logic [6:0] chr_d [CHR_SLOTS];

	logic [4:0] shv, nv, base, fix_lo, fix_hi;
	logic [2:0] shc, nc;
	logic       chr_hi, four_kb;

	assign fix_lo = prg_page_count[4:0] - 5'd2;
	assign fix_hi = prg_page_count[4:0] - 5'd1;

	always_comb begin
		shift_value_d = shift_value_q;
		shift_count_d = shift_count_q;
		last_region_d = last_region_q;
		regs_d        = regs_q;
		prg_d         = prg_q;
		chr_d         = chr_q;
		result        = '0;
		shv           = shift_value_q;
		shc           = shift_count_q;
		nv            = '0;
		nc            = '0;
		base          = '0;
		chr_hi        = (item.region == REG_CHR1);
		four_kb       = regs_q[REG_CONTROL][4];
		unique case (kind_t'(item.kind))
			KIND_WRITE: begin
				if (item.region != last_region_q) begin
					shv = '0;
					shc = '0;
				end
				shift_value_d = shv;
				shift_count_d = shc;
				last_region_d = item.region;
				if (item.data[7]) begin
					shift_value_d       = '0;
					shift_count_d       = '0;
					regs_d[REG_CONTROL] = regs_q[REG_CONTROL] | CTL_RESET_BITS;
					prg_d[2]            = fix_lo;
					prg_d[3]            = fix_hi;
				end else begin
					nv            = {item.data[0], shv[4:1]};
					nc            = shc + 3'd1;
					shift_value_d = nv;
					shift_count_d = nc;
					if (nc == SHIFT_BITS) begin
						regs_d[item.region]     = nv;
						shift_count_d           = '0;
						result.committed        = 1'b1;
						result.written_register = item.region;
						if (item.region == REG_CHR0 || item.region == REG_CHR1) begin
							if (chr_rom_present) begin
								if (four_kb) begin
									for (int i = 0; i < 4; i++)
										chr_d[{chr_hi, 2'(i)}] = {nv[4:1], nv[0], 2'(i)};
								end else if (item.region == REG_CHR0) begin
									for (int i = 0; i < CHR_SLOTS; i++)
										chr_d[i] = {nv[4:1], 3'(i)};
								end
							end else if (four_kb) begin
								for (int i = 0; i < 4; i++)
									chr_d[{chr_hi, 2'(i)}] = {1'b0, nv[4:1], 2'(i)};
							end
						end else if (item.region == REG_PRG) begin
							if (regs_q[REG_CONTROL][3]) begin
								// 16 KB: bit 2 picks the switched half
								base = {nv[3:0], 1'b0};
								if (regs_q[REG_CONTROL][2]) begin
									prg_d[0] = base;
									prg_d[1] = base | 5'd1;
								end else begin
									prg_d[2] = base;
									prg_d[3] = base | 5'd1;
								end
							end else begin
								base = {nv[3:1], 2'b00};
								for (int i = 0; i < PRG_SLOTS; i++)
									prg_d[i] = base | 5'(i);
							end
						end
					end
				end
			end
			KIND_READ:       result.read_value = regs_q[item.region];
			KIND_PRG_LOOKUP: result.page = {2'b00, prg_q[item.slot[1:0]]};
			KIND_CHR_LOOKUP: result.page = chr_q[item.slot];
			default:         result = '0;
		endcase
		result.mirroring = regs_d[REG_CONTROL][1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q <= '0;
			shift_count_q <= '0;
			last_region_q <= '0;
			regs_q[0]     <= CONTROL_RESET;
			regs_q[1]     <= '0;
			regs_q[2]     <= '0;
			regs_q[3]     <= '0;
			prg_q[0]      <= 5'd0;
			prg_q[1]      <= 5'd1;
			prg_q[2]      <= 5'(PRG_PAGE_COUNT_RESET - 6'd2);
			prg_q[3]      <= 5'(PRG_PAGE_COUNT_RESET - 6'd1);
			for (int i = 0; i < CHR_SLOTS; i++)
				chr_q[i] <= 7'(i);
		end else if (step) begin
			shift_value_q <= shift_value_d;
			shift_count_q <= shift_count_d;
			last_region_q <= last_region_d;
			regs_q        <= regs_d;
			prg_q         <= prg_d;
			chr_q         <= chr_d;
		end
	end

endmodule

[src/serial_bank_switch_mapper_unit.sv]
// Serial-loaded bank-switching mapper. Each word on the item channel is a CPU write
// (five serial bits load one of four registers), a register read or a slot lookup,
// and yields exactly one result word through the input register and the result
// register, the mapping state updating as it enters the latter. The result register
// decouples the two sides: one word is taken per cycle, the item channel stalling
// only while a result is held. Configuration (page count, CHR ROM/RAM) is to be
// written through cfg_wr_en while idle; the block itself does not enforce this.
module serial_bank_switch_mapper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [0:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] kind,
	input  logic [1:0] region,
	input  logic [7:0] data,
	input  logic [2:0] slot,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [4:0] read_value,
	output logic [6:0] page,
	output logic       committed,
	output logic [1:0] written_register,
	output logic [1:0] mirroring
);
	import sbsm_pkg::*;

	logic [5:0] prg_page_count_q;
	logic       chr_rom_present_q;
	logic       valid_s1;
	item_t      item_s1;
	logic       result_valid_q;
	result_t    result_q;
	result_t    core_result;
	logic       step;

	assign step       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_page_count_q  <= PRG_PAGE_COUNT_RESET;
			chr_rom_present_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PRG_PAGE_COUNT:  prg_page_count_q  <= cfg_data;
				CFG_CHR_ROM_PRESENT: chr_rom_present_q <= cfg_data[0];
				default:             prg_page_count_q  <= prg_page_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (step)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= '{kind: kind, region: region, data: data, slot: slot};
		if (step)
			result_q <= core_result;
	end

	sbsm_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.prg_page_count  (prg_page_count_q),
		.chr_rom_present (chr_rom_present_q),
		.step            (step),
		.item            (item_s1),
		.result          (core_result)
	);

	assign result_valid     = result_valid_q;
	assign read_value       = result_q.read_value;
	assign page             = result_q.page;
	assign committed        = result_q.committed;
	assign written_register = result_q.written_register;
	assign mirroring        = result_q.mirroring;

endmodule

[src/sbsm_checker.sv]
module sbsm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [4:0] read_value,
	input logic [6:0] page,
	input logic       committed,
	input logic [1:0] written_register
);

	// input side backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item stalled without a held result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	// a commit comes from a write: no read or lookup fields
	a_commit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && committed |-> read_value == 5'd0 && page == 7'd0)
		else $error("commit word carries read or page data");

	a_written_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !committed |-> written_register == 2'd0)
		else $error("register index without a commit");

endmodule

bind serial_bank_switch_mapper_unit sbsm_checker u_sbsm_checker (.*);
